// File: hw/rtl/hrde_pkg.sv
// Shared types, constants and decode functions for the hex record data extractor.
package hrde_pkg;

  // Character that ends a line of hex text.
  localparam logic [7:0] CharNewline = 8'd10;

  // Character positions within one record line.
  localparam int unsigned PosW = 10;
  localparam logic [PosW-1:0] PosMax     = 10'd1023;
  localparam logic [PosW-1:0] PosCountHi = 10'd1;
  localparam logic [PosW-1:0] PosCountLo = 10'd2;
  localparam logic [PosW-1:0] PosTypeHi  = 10'd7;
  localparam logic [PosW-1:0] PosTypeLo  = 10'd8;
  localparam logic [PosW-1:0] PosData    = 10'd9;

  // Data byte index within a record, wide enough for any saturated position.
  localparam int unsigned IdxW = PosW - 1;

  // Record type that carries data.
  localparam logic [7:0] RecTypeData = 8'h00;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One result waiting for delivery.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_record;
  } item_t;

  // Hex digit value of an ASCII character; anything that is not a digit gives zero.
  function automatic logic [3:0] digit_value(input logic [7:0] ch);
    logic [3:0] val;
    val = 4'd0;
    if (ch >= 8'd48 && ch <= 8'd57) begin
      val = 4'(ch - 8'd48);
    end else if (ch >= 8'd65 && ch <= 8'd70) begin
      val = 4'(ch - 8'd55);
    end else if (ch >= 8'd97 && ch <= 8'd102) begin
      val = 4'(ch - 8'd87);
    end
    return val;
  endfunction

  // Reverse the bit order of a byte.
  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/hrde_front.sv
// Front part: tracks the position in each line, decodes header fields and data pairs.
module hrde_front #(
  parameter int unsigned MAX_RECORD_BYTES = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,  // a character transaction completes
  input  logic [7:0]         char_i,
  output logic               push_o,
  output hrde_pkg::item_t    item_o
);
  import hrde_pkg::*;

  localparam logic [7:0] MaxBytes = 8'(MAX_RECORD_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      count_q, count_d;
  logic [7:0]      type_q, type_d;
  logic [3:0]      nibble_q, nibble_d;

  logic            is_newline;
  logic [3:0]      digit;
  logic [PosW-1:0] data_off;
  logic [IdxW-1:0] idx;
  logic [7:0]      limit;
  logic            in_data;
  logic            low_digit;

  assign is_newline = (char_i == CharNewline);
  assign digit      = digit_value(char_i);
  assign in_data    = (pos_q >= PosData);
  assign data_off   = pos_q - PosData;
  assign low_digit  = data_off[0];
  assign idx        = data_off[PosW-1:1];
  assign limit      = (count_q > MaxBytes) ? MaxBytes : count_q;

  // Field decode and position update for each accepted character.
  always_comb begin
    pos_d    = pos_q;
    count_d  = count_q;
    type_d   = type_q;
    nibble_d = nibble_q;
    if (accept_i) begin
      if (is_newline) begin
        pos_d    = '0;
        count_d  = '0;
        type_d   = '0;
        nibble_d = '0;
      end else begin
        if (pos_q == PosCountHi || pos_q == PosTypeHi) begin
          nibble_d = digit;
        end else if (pos_q == PosCountLo) begin
          count_d = {nibble_q, digit};
        end else if (pos_q == PosTypeLo) begin
          type_d = {nibble_q, digit};
        end else if (in_data && !low_digit) begin
          nibble_d = digit;
        end
        if (pos_q < PosMax) begin
          pos_d = pos_q + 10'd1;
        end
      end
    end
  end

  // A second digit of a pair inside the byte count of a data record gives a result.
  assign push_o = accept_i && !is_newline && in_data && low_digit &&
                  (type_q == RecTypeData) && (idx < {1'b0, limit});
  assign item_o.data_byte      = reverse8({nibble_q, digit});
  assign item_o.last_of_record = ((idx + 9'd1) == {1'b0, limit});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      count_q  <= '0;
      type_q   <= '0;
      nibble_q <= '0;
    end else begin
      pos_q    <= pos_d;
      count_q  <= count_d;
      type_q   <= type_d;
      nibble_q <= nibble_d;
    end
  end

  // A result is only ever produced for a data record and within its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (type_q == RecTypeData) && (limit != 8'd0))
    else $error("front: result outside a data record");

  // After a newline the next line starts at position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && is_newline) |=> (pos_q == '0) && (count_q == '0))
    else $error("front: line state not cleared by newline");

  // The position never moves without an accepted character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(pos_q))
    else $error("front: position moved without a character");

endmodule

// File: hw/rtl/hrde_queue.sv
// Back part: a short queue of decoded results that drives the output stream.
module hrde_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hrde_pkg::item_t item_i,
  output logic            full_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // bits 7:0 data_byte
  output logic            m_axis_tlast_o
);
  import hrde_pkg::*;

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign pop    = m_axis_tvalid_o && m_axis_tready_i;
  assign full_o = (cnt_q == QueueCntW'(QueueDepth));

  // Storage is written at the tail only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // The head entry is presented on the output stream.
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = mem_q[rd_ptr_q].data_byte;
  assign m_axis_tlast_o  = mem_q[rd_ptr_q].last_of_record;

  // Occupancy never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue: occupancy beyond depth");

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue: push while full");

  // Occupancy tracks the pointer distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != QueueCntW'(QueueDepth)) |->
      (wr_ptr_q - rd_ptr_q) == cnt_q[QueuePtrW-1:0])
    else $error("queue: pointers disagree with occupancy");

endmodule

// File: hw/rtl/hex_record_data_extractor_unit.sv
// Top level of the hex record data extractor: front decoder and result queue.
//
// Takes Intel HEX text one character per transaction on the input stream and
// delivers the data bytes of type 0 records, bit-reversed, on the output stream,
// with tlast marking the final byte of a record (at most MAX_RECORD_BYTES per
// record). A newline starts a new record; the first character of each line is
// skipped, the address and checksum are ignored, and non-hex characters decode
// as zero. One character is accepted every cycle; the decoder holds only a
// position counter and a few header registers, and a four-entry result queue
// parts the input from the output, so the input stalls only when that queue is
// full because the output side is not taking results. Each result is registered
// in the queue before it is presented on the output. There is no clearing pass
// after reset.
module hex_record_data_extractor_unit #(
  parameter int unsigned MAX_RECORD_BYTES = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // bits 7:0 char_in
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // bits 7:0 data_byte
  output logic       m_axis_tlast_o
);
  import hrde_pkg::*;

  logic  accept;
  logic  push;
  logic  full;
  item_t item;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Character decode.
  hrde_front #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .char_i  (s_axis_tdata_i),
    .push_o  (push),
    .item_o  (item)
  );

  // Result queue and output stream.
  hrde_queue u_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .item_i         (item),
    .full_o         (full),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for the hex record data extractor: random HEX text in, data bytes checked out.
module tb;
  import hrde_pkg::*;

  localparam int unsigned MaxRecordBytes = 255;
  localparam int unsigned StimChars      = 1950;
  localparam int unsigned DrainCycles    = 16;
  localparam int unsigned LongLineLen    = 1045;
  localparam int unsigned MaxPrinted     = 50;
  localparam logic [7:0]  CharColon      = 8'h3A;
  localparam logic [7:0]  CharCr         = 8'h0D;

  // Scoreboard: follows the line decode state and holds the data bytes still owed.
  class byte_scoreboard;
    logic [PosW-1:0] line_pos;
    logic [7:0]      count_q;
    logic [7:0]      rtype_q;
    logic [3:0]      nibble_q;
    item_t           owed_bytes[$];
    int unsigned     error_count;
    int unsigned     checked_count;

    function new();
      clear_line();
      error_count   = 0;
      checked_count = 0;
    endfunction

    function void clear_line();
      line_pos = '0;
      count_q  = '0;
      rtype_q  = '0;
      nibble_q = '0;
    endfunction

    // Digits and letters A to F share their low nibble layout in ASCII.
    static function logic [3:0] hex_val(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") begin
        return ch[3:0];
      end
      if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) begin
        return ch[3:0] + 4'd9;
      end
      return 4'd0;
    endfunction

    static function logic [7:0] flip(input logic [7:0] v);
      return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
    endfunction

    // Advance the line state by one accepted character and queue any byte it completes.
    function void note_char(input logic [7:0] ch);
      logic [3:0]      d;
      logic [PosW-1:0] off;
      int unsigned     idx;
      int unsigned     lim;
      item_t           it;
      if (ch == CharNewline) begin
        clear_line();
        return;
      end
      d = hex_val(ch);
      if (line_pos == PosCountHi || line_pos == PosTypeHi) begin
        nibble_q = d;
      end else if (line_pos == PosCountLo) begin
        count_q = {nibble_q, d};
      end else if (line_pos == PosTypeLo) begin
        rtype_q = {nibble_q, d};
      end else if (line_pos >= PosData) begin
        off = line_pos - PosData;
        if (!off[0]) begin
          nibble_q = d;
        end else begin
          idx = off >> 1;
          lim = (count_q > MaxRecordBytes) ? MaxRecordBytes : count_q;
          if (rtype_q == RecTypeData && idx < lim) begin
            it.data_byte      = flip({nibble_q, d});
            it.last_of_record = (idx + 1 == lim);
            owed_bytes.push_back(it);
          end
        end
      end
      if (line_pos < PosMax) begin
        line_pos = line_pos + 1'b1;
      end
    endfunction

    task report(input string msg);
      if (error_count < MaxPrinted) begin
        $display("MISMATCH at %0t: %s", $time, msg);
      end
      error_count++;
    endtask

    // Compare one delivered byte with the oldest one owed.
    task check_byte(input logic [7:0] data, input logic last_flag);
      item_t want;
      checked_count++;
      if (owed_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", data, last_flag));
      end else begin
        want = owed_bytes.pop_front();
        if (data !== want.data_byte) begin
          report($sformatf("data byte %02h, wanted %02h", data, want.data_byte));
        end
        if (last_flag !== want.last_of_record) begin
          report($sformatf("last flag %0b, wanted %0b (byte %02h)", last_flag,
                           want.last_of_record, want.data_byte));
        end
      end
    endtask

    function int unsigned pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid   = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata    = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready   = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  byte_scoreboard sb = new();

  logic [7:0]  line_buf[$];
  int unsigned burst_left  = 0;
  int unsigned total_chars = 0;
  int unsigned total_lines = 0;

  always #5 clk_i = ~clk_i;

  hex_record_data_extractor_unit #(
    .MAX_RECORD_BYTES(MaxRecordBytes)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // Output monitor: every transaction on the master side is checked.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_byte(m_axis_tdata, m_axis_tlast);
    end
  end

  // Receiver back-pressure: the stall pattern changes at random among four modes.
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall     = 0;
  int unsigned rx_cycle     = 0;
  always @(negedge clk_i) begin
    logic rdy;
    rx_cycle++;
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(32, 256);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: begin
        rdy = 1'b1;
      end
      1: begin
        rdy = 1'($urandom_range(0, 1));
      end
      2: begin
        rdy = (rx_cycle % 4 != 0);
      end
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          rdy = 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_stall = $urandom_range(1, 20);
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
        end
      end
    endcase
    m_axis_tready <= rdy;
  end

  // Offer one character and wait for its transaction; gaps come between bursts.
  task send_char(input logic [7:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 40);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    sb.note_char(ch);
    burst_left--;
    total_chars++;
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
    total_lines++;
  endtask

  task send_line();
    foreach (line_buf[i]) begin
      send_char(line_buf[i]);
    end
    total_lines++;
  endtask

  // Hold the input until every owed byte has been delivered.
  task hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CharNewline) begin
      c = 8'hFF;
    end
    return c;
  endfunction

  // A hex digit in random case, or now and then a stray character.
  function logic [7:0] digit_char(input logic [3:0] v, input bit noisy);
    if (noisy && $urandom_range(0, 29) == 0) begin
      return junk_char();
    end
    if (v < 10) begin
      return "0" + v;
    end
    return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
  endfunction

  function void push_hex(input logic [7:0] b, input bit noisy);
    line_buf.push_back(digit_char(b[7:4], noisy));
    line_buf.push_back(digit_char(b[3:0], noisy));
  endfunction

  // Build a complete record line: start, count, address, type, data, checksum.
  function void build_record(input logic [7:0] count, input logic [7:0] rtype,
                             input bit noisy);
    line_buf.delete();
    line_buf.push_back(($urandom_range(0, 7) == 0) ? junk_char() : CharColon);
    push_hex(count, noisy);
    push_hex(8'($urandom_range(0, 255)), noisy);
    push_hex(8'($urandom_range(0, 255)), noisy);
    push_hex(rtype, noisy);
    for (int i = 0; i < count; i++) begin
      push_hex(8'($urandom_range(0, 255)), noisy);
    end
    push_hex(8'($urandom_range(0, 255)), noisy);
    if ($urandom_range(0, 3) == 0) begin
      line_buf.push_back(CharCr);
    end
    line_buf.push_back(CharNewline);
  endfunction

  // Largest record, padded past the saturation point of the line position.
  function void build_long_line();
    build_record(8'hFF, RecTypeData, 1'b0);
    void'(line_buf.pop_back());
    while (line_buf.size() < LongLineLen - 1) begin
      line_buf.push_back(digit_char(4'($urandom_range(0, 15)), 1'b0));
    end
    line_buf.push_back(CharNewline);
  endfunction

  function void build_random_line();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  count;
    logic [7:0]  rtype;
    kind  = $urandom_range(0, 99);
    count = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8));
    rtype = ($urandom_range(0, 4) != 0) ? RecTypeData
          : 8'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 5) : $urandom_range(1, 255));
    build_record(count, rtype, $urandom_range(0, 4) == 0);
    if (kind >= 70 && kind < 80) begin
      // Newline arrives early, cutting the record short.
      n = $urandom_range(1, line_buf.size() - 1);
      while (line_buf.size() > n) begin
        void'(line_buf.pop_back());
      end
      line_buf.push_back(CharNewline);
    end else if (kind >= 80 && kind < 88) begin
      // More digit pairs than the byte count announces.
      void'(line_buf.pop_back());
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        push_hex(8'($urandom_range(0, 255)), 1'b0);
      end
      line_buf.push_back(CharNewline);
    end else if (kind >= 88) begin
      // Pure noise.
      line_buf.delete();
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        line_buf.push_back(junk_char());
      end
      line_buf.push_back(CharNewline);
    end
  endfunction

  // Main stimulus sequence.
  initial begin
    int unsigned line_no;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: skipped first character of the stream, extreme bytes, both digit cases,
    // a stray character in a digit position and a record cut short by a newline.
    send_text("502000000Ff00\n");
    send_text(":02000000aG\n");
    hold_until_drained();

    line_no = 0;
    while (total_chars < StimChars) begin
      if (line_no == 2) begin
        build_long_line();
      end else begin
        build_random_line();
      end
      send_line();
      line_no++;
      if (line_no == 40) begin
        hold_until_drained();
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d bytes never delivered", sb.pending()));
    end

    $display("Covered %0d characters in %0d lines, one of %0d characters with 255 data bytes.",
             total_chars, total_lines, LongLineLen);
    $display("Checked %0d delivered data bytes; %0d mismatches.", sb.checked_count,
             sb.error_count);
    if (sb.error_count == 0) begin
      $display("hex_record_data_extractor_unit verification clean");
    end else begin
      $display("hex_record_data_extractor_unit verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("hex_record_data_extractor_unit verification failed");
    $finish;
  end

endmodule
